@@ rtl/cclf_pkg.sv @@
// Shared types and constants of the contour corner line-fit unit.
`default_nettype none

package cclf_pkg;

    // Widths of the fixed result fields.
    localparam int RES_BITS = 24;
    localparam int IDX_BITS = 16;

    // Corner threshold after reset: 2.0 in Q16.8.
    localparam logic [RES_BITS-1:0] THR_RESET = 24'd512;

    // Largest residual that the output can carry.
    localparam logic [RES_BITS-1:0] RES_MAX = '1;

    // Fraction bits of the residual.
    localparam int FRAC_BITS = 8;

    typedef logic [RES_BITS-1:0] t_res;
    typedef logic [IDX_BITS-1:0] t_idx;

endpackage

`default_nettype wire

@@ rtl/contour_corner_line_fit_unit.sv @@
// Top level of the contour corner line-fit unit: sequencer, shared multiplier and subtractor.
//
//  Channel | Direction | Handshake                 | Payload
//  --------+-----------+---------------------------+----------------------------------------
//  in      | input     | i_in_valid / o_in_ready   | i_x_coord, i_y_coord, i_end_of_contour
//  cfg     | input     | i_cfg_valid / o_cfg_ready | i_cfg_data (corner threshold)
//  out     | output    | o_out_valid / i_out_ready | o_point_index ... o_last_out
//
// An input request that yields no result is accepted without leaving the idle state. Each
// result takes the products over the window (W = 2*HALF_WINDOW+1) on the one shared
// multiplier, a 32-step square root and a 24-step restoring divide on the shared
// subtractor; normalizing shifts one bit per step; a saturating result skips the divide.
// An end mark yields up to 2*HALF_WINDOW+1 results one after another on the same sequencer.
// Synchronous active-low reset clears the sequencer and count and loads the reset threshold.
// A result waits in the output register while the next input request is accepted.
`default_nettype none

module contour_corner_line_fit_unit #(
    parameter int COORD_BITS  = 12,
    parameter int HALF_WINDOW = 3,
    parameter int COUNT_BITS  = 16
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_in_valid,
    output logic                         o_in_ready,
    input  wire [COORD_BITS-1:0]         i_x_coord,
    input  wire [COORD_BITS-1:0]         i_y_coord,
    input  wire                          i_end_of_contour,
    input  wire                          i_cfg_valid,
    output logic                         o_cfg_ready,
    input  wire cclf_pkg::t_res          i_cfg_data,
    output logic                         o_out_valid,
    input  wire                          i_out_ready,
    output cclf_pkg::t_idx               o_point_index,
    output logic [COORD_BITS-1:0]        o_x_out,
    output logic [COORD_BITS-1:0]        o_y_out,
    output cclf_pkg::t_res               o_residual,
    output logic                         o_is_corner,
    output logic                         o_last_out
);
    import cclf_pkg::*;

    localparam int W     = 2 * HALF_WINDOW + 1;
    localparam int HEADN = 2 * HALF_WINDOW;
    localparam int SEQN  = W + HEADN;
    localparam int SB    = $clog2(SEQN);
    localparam int WIB   = $clog2(W);
    localparam int HIB   = $clog2(HEADN);
    localparam int OB    = $clog2(HEADN + 1);
    localparam int PW    = 2 * COORD_BITS;
    localparam int SUMW  = COORD_BITS + 3;
    localparam int DW    = COORD_BITS + 4;
    localparam int SXW   = 2 * DW + 3;
    localparam int AW    = (SXW - 1 > 31) ? SXW - 1 : 31;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    typedef enum logic [3:0] {
        S_IDLE, S_SUM, S_SXX, S_CHK, S_NORM, S_SQ, S_SQRT, S_ACC, S_DIVI, S_DIV, S_EMIT
    } t_state;

    t_state                  r_state;
    logic [PW-1:0]           r_win  [W];
    logic [PW-1:0]           r_head [HEADN];
    logic [COUNT_BITS-1:0]   r_count;
    logic [COUNT_BITS-1:0]   r_n;
    logic                    r_end;
    logic [OB-1:0]           r_o;
    logic [WIB-1:0]          r_k;
    logic [1:0]              r_ph;
    logic [SUMW-1:0]         r_sumx;
    logic [SUMW-1:0]         r_sumy;
    logic signed [SXW-1:0]   r_sxx;
    logic signed [SXW-1:0]   r_sxy;
    logic [AW-1:0]           r_a;
    logic [AW-1:0]           r_b;
    logic                    r_neg;
    logic [63:0]             r_v;
    logic [63:0]             r_root;
    logic [63:0]             r_bit;
    logic signed [63:0]      r_p;
    logic [63:0]             r_acc;
    logic [63:0]             r_div;
    logic [63:0]             r_rem;
    logic [RES_BITS-1:0]     r_q;
    logic [4:0]              r_dk;
    t_res                    r_res;
    t_res                    r_thr;
    logic                    r_out_valid;

    // Window point at a position of the joined sequence: window, then head points.
    function automatic logic [PW-1:0] seq_pt(input logic [SB-1:0] s);
        logic [SB-1:0] h;
        h = s - SB'(W);
        if (s < SB'(W)) begin
            return r_win[s[WIB-1:0]];
        end
        return r_head[h[HIB-1:0]];
    endfunction

    // Current window point and its deviations from the scaled mean.
    logic [SB-1:0]          pt_sel;
    logic [PW-1:0]          pt;
    logic [SUMW-1:0]        wx;
    logic [SUMW-1:0]        wy;
    logic signed [DW-1:0]   dx;
    logic signed [DW-1:0]   dy;
    logic [PW-1:0]          ctr;

    assign pt_sel = SB'(r_o) + SB'(r_k);
    assign pt     = seq_pt(pt_sel);
    assign ctr    = seq_pt(SB'(r_o) + SB'(HALF_WINDOW));
    assign wx     = SUMW'(pt[COORD_BITS-1:0]) * SUMW'(W);
    assign wy     = SUMW'(pt[PW-1:COORD_BITS]) * SUMW'(W);
    assign dx     = $signed(DW'(wx)) - $signed(DW'(r_sumx));
    assign dy     = $signed(DW'(wy)) - $signed(DW'(r_sumy));

    // Shared signed multiplier.
    logic signed [31:0] mul_a;
    logic signed [31:0] mul_b;
    logic signed [63:0] mul_p;
    logic signed [31:0] sa;
    logic signed [31:0] sb;

    assign sa = $signed({1'b0, r_a[30:0]});
    assign sb = r_neg ? -$signed({1'b0, r_b[30:0]}) : $signed({1'b0, r_b[30:0]});

    always_comb begin
        mul_a = 32'(dx);
        mul_b = 32'(dx);
        case (r_state)
            S_SXX: begin
                mul_a = 32'(dx);
                mul_b = (r_ph == 2'd0) ? 32'(dx) : 32'(dy);
            end
            S_SQ: begin
                mul_a = (r_ph == 2'd0) ? sa : $signed({1'b0, r_b[30:0]});
                mul_b = mul_a;
            end
            S_ACC: begin
                mul_a = (r_ph == 2'd0) ? sa : sb;
                mul_b = (r_ph == 2'd0) ? 32'(dy) : 32'(dx);
            end
            default: begin
                mul_a = 32'(dx);
                mul_b = 32'(dx);
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // Shared compare and subtract for the root, the saturation check and the divide.
    logic [63:0] cmp_a;
    logic [63:0] cmp_b;
    logic [63:0] cmp_diff;
    logic        cmp_ge;

    always_comb begin
        case (r_state)
            S_SQRT: begin
                cmp_a = r_v;
                cmp_b = r_root + r_bit;
            end
            S_DIVI: begin
                cmp_a = r_acc << FRAC_BITS;
                cmp_b = r_div << RES_BITS;
            end
            default: begin
                cmp_a = r_rem;
                cmp_b = r_div << r_dk;
            end
        endcase
    end

    assign cmp_ge   = cmp_a >= cmp_b;
    assign cmp_diff = cmp_a - cmp_b;

    // Input bookkeeping.
    logic                  in_acc;
    logic                  out_free;
    logic [COUNT_BITS-1:0] cnt_inc;
    logic [PW-1:0]         in_pt;
    logic [63:0]           abs_p;
    logic [SXW-1:0]        abs_sxy;
    logic [COUNT_BITS-1:0] idx;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign in_acc      = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;
    assign cnt_inc     = (r_count < COUNT_MAX) ? r_count + 1'b1 : r_count;
    assign in_pt       = {i_y_coord, i_x_coord};
    assign abs_p       = r_p[63] ? 64'(-r_p) : 64'(r_p);
    assign abs_sxy     = r_sxy[SXW-1] ? SXW'(-r_sxy) : SXW'(r_sxy);
    assign idx         = (r_o <= OB'(HALF_WINDOW))
                       ? r_n - COUNT_BITS'(HALF_WINDOW + 1) + COUNT_BITS'(r_o)
                       : COUNT_BITS'(r_o) - COUNT_BITS'(HALF_WINDOW + 1);

    // Point storage: sliding window and the first points of the contour.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            for (int i = 0; i < W - 1; i++) begin
                r_win[i] <= r_win[i+1];
            end
            r_win[W-1] <= in_pt;
            if (r_count < COUNT_BITS'(HEADN)) begin
                r_head[r_count[HIB-1:0]] <= in_pt;
            end
        end
    end

    // Threshold register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= THR_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_thr <= i_cfg_data;
        end
    end

    // Sequencer, datapath registers and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // A result taken while the next one loads is replaced in the emit state.
            if (r_out_valid && i_out_ready && r_state != S_EMIT) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_count <= i_end_of_contour ? '0 : cnt_inc;
                        r_n     <= cnt_inc;
                        r_end   <= i_end_of_contour;
                        r_o     <= '0;
                        r_k     <= '0;
                        r_sumx  <= '0;
                        r_sumy  <= '0;
                        if (cnt_inc >= COUNT_BITS'(W)) begin
                            r_state <= S_SUM;
                        end
                    end
                end
                S_SUM: begin
                    r_sumx <= r_sumx + SUMW'(pt[COORD_BITS-1:0]);
                    r_sumy <= r_sumy + SUMW'(pt[PW-1:COORD_BITS]);
                    if (r_k == WIB'(W - 1)) begin
                        r_k     <= '0;
                        r_ph    <= 2'd0;
                        r_sxx   <= '0;
                        r_sxy   <= '0;
                        r_state <= S_SXX;
                    end else begin
                        r_k <= r_k + 1'b1;
                    end
                end
                S_SXX: begin
                    if (r_ph == 2'd0) begin
                        r_sxx <= r_sxx + SXW'(mul_p);
                        r_ph  <= 2'd1;
                    end else begin
                        r_sxy <= r_sxy + SXW'(mul_p);
                        r_ph  <= 2'd0;
                        if (r_k == WIB'(W - 1)) begin
                            r_state <= S_CHK;
                        end else begin
                            r_k <= r_k + 1'b1;
                        end
                    end
                end
                S_CHK: begin
                    // All x equal: every deviation is zero and so is the residual.
                    if (r_sxx == '0) begin
                        r_res   <= '0;
                        r_state <= S_EMIT;
                    end else begin
                        r_a     <= AW'(r_sxx);
                        r_b     <= AW'(abs_sxy);
                        r_neg   <= r_sxy[SXW-1];
                        r_state <= S_NORM;
                    end
                end
                S_NORM: begin
                    if ((r_a >> 31) != '0 || (r_b >> 31) != '0) begin
                        r_a <= r_a >> 1;
                        r_b <= r_b >> 1;
                    end else begin
                        r_ph    <= 2'd0;
                        r_state <= S_SQ;
                    end
                end
                S_SQ: begin
                    if (r_ph == 2'd0) begin
                        r_v  <= 64'(mul_p);
                        r_ph <= 2'd1;
                    end else begin
                        r_v     <= r_v + 64'(mul_p);
                        r_root  <= '0;
                        r_bit   <= 64'd1 << 62;
                        r_state <= S_SQRT;
                    end
                end
                S_SQRT: begin
                    // One result bit of the root per step.
                    if (cmp_ge) begin
                        r_v    <= cmp_diff;
                        r_root <= (r_root >> 1) + r_bit;
                    end else begin
                        r_root <= r_root >> 1;
                    end
                    r_bit <= r_bit >> 2;
                    if (r_bit == 64'd1) begin
                        r_k     <= '0;
                        r_ph    <= 2'd0;
                        r_acc   <= '0;
                        r_state <= S_ACC;
                    end
                end
                S_ACC: begin
                    if (r_state == S_ACC && r_k == '0 && r_ph == 2'd0) begin
                        r_div <= (r_root == '0) ? 64'(W) : 64'(r_root[31:0]) * 64'(W);
                    end
                    case (r_ph)
                        2'd0: begin
                            r_p  <= mul_p;
                            r_ph <= 2'd1;
                        end
                        2'd1: begin
                            r_p  <= r_p - mul_p;
                            r_ph <= 2'd2;
                        end
                        default: begin
                            r_acc <= r_acc + abs_p;
                            r_ph  <= 2'd0;
                            if (r_k == WIB'(W - 1)) begin
                                r_state <= S_DIVI;
                            end else begin
                                r_k <= r_k + 1'b1;
                            end
                        end
                    endcase
                end
                S_DIVI: begin
                    // Quotient too large for the field saturates without dividing.
                    if (cmp_ge) begin
                        r_res   <= RES_MAX;
                        r_state <= S_EMIT;
                    end else begin
                        r_rem   <= cmp_a;
                        r_q     <= '0;
                        r_dk    <= 5'(RES_BITS - 1);
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (cmp_ge) begin
                        r_rem       <= cmp_diff;
                        r_q[r_dk]   <= 1'b1;
                    end
                    if (r_dk == '0) begin
                        r_res   <= r_q | (cmp_ge ? t_res'(1) : t_res'(0));
                        r_state <= S_EMIT;
                    end else begin
                        r_dk <= r_dk - 1'b1;
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_out_valid   <= 1'b1;
                        o_point_index <= IDX_BITS'(idx);
                        o_x_out       <= ctr[COORD_BITS-1:0];
                        o_y_out       <= ctr[PW-1:COORD_BITS];
                        o_residual    <= r_res;
                        o_is_corner   <= r_res > r_thr;
                        o_last_out    <= r_end && (r_o == OB'(HEADN));
                        if (r_end && r_o != OB'(HEADN)) begin
                            r_o     <= r_o + 1'b1;
                            r_k     <= '0;
                            r_sumx  <= '0;
                            r_sumy  <= '0;
                            r_state <= S_SUM;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;

    // The square stage sees operands already normalized below 2^31.
    a_norm_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SQ) |-> ((r_a >> 31) == '0 && (r_b >> 31) == '0))
        else $error("line fit: operands not normalized before squaring");

    // An end mark always restarts the point count.
    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_end_of_contour) |=> (r_count == '0))
        else $error("line fit: count not cleared by end of contour");

    // The divide remainder stays below the divisor at the weight above the current one.
    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_rem < (r_div << (6'(r_dk) + 6'd1))))
        else $error("line fit: divide remainder out of range");

    // The final result of a contour returns the sequencer to idle.
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && out_free && r_end && r_o == OB'(HEADN))
        |=> (r_out_valid && o_last_out && r_state == S_IDLE))
        else $error("line fit: final result did not end the contour");

endmodule

`default_nettype wire
